[rtl/core/mpq_pkg.sv]
// Package for the min priority queue: field widths, opcode and status codes,
// and the command struct that the top level broadcasts to the cell row.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0]        count_t;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell in the row
    typedef struct packed
    {
        logic ins;      // sorted insert of the new value
        logic del;      // drop the head, everything moves one cell left
    } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/core/mpq_req_if.sv]
// Request channel of the min priority queue: valid/ready plus op and value.
// Depends on mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mpq_req_if
    import mpq_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   op;
    value_t value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

[rtl/core/mpq_rsp_if.sv]
// Response channel of the min priority queue: valid/ready plus status,
// removed value and entry count. Depends on mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mpq_rsp_if
    import mpq_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    value_t     removed_value;
    count_t     entry_count;

    modport source (output valid, output status, output removed_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input entry_count, output ready);
endinterface

`default_nettype wire

[rtl/core/min_priority_queue.sv]
// Min priority queue: a row of CAPACITY cells kept sorted ascending.
//
// Usage:
//   req carries op (insert / remove-min) and a signed 32-bit value; rsp
//   returns one word per request: status, removed value, entry count.
//   Insert places the value behind every stored value that is less or
//   equal, so the head always holds the minimum, earliest arrived first.
//   Remove takes the head and every cell moves one place toward it.
// Timing:
//   One request per cycle while rsp is not held. The response word appears
//   in the cycle after the request is accepted, from the output register;
//   the cell row settles at the same edge, since every cell compares against
//   the broadcast value and trades with its neighbor at that edge.
// Reset:
//   rst_n clears the count and the response valid; cell contents are not
//   cleared and are only read below the count.
// Stall:
//   While rsp is held (valid and not ready) req.ready is low; it is high
//   whenever the output register is empty or is being taken.
// Depends on mpq_pkg, mpq_req_if, mpq_rsp_if, mpq_cell.
`timescale 1ns / 1ps
`default_nettype none

module min_priority_queue
    import mpq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    mpq_req_if.sink   req,
    mpq_rsp_if.source rsp
);

    localparam int CntW = $clog2(CAPACITY + 1);

    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    status_t         status_reg;
    status_t         status_next;
    value_t          removed_reg;
    value_t          removed_next;
    count_t          entry_count_reg;
    count_t          entry_count_next;

    logic            accept;
    logic            is_full;
    logic            is_empty;
    cell_cmd_t       cmd;

    value_t          cell_value [CAPACITY];
    logic            cell_keep  [CAPACITY];

    assign accept   = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign is_full  = (count_reg == CntW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Command to the row
    always_comb
    begin
        cmd.ins = accept && (op_t'(req.op) == OP_INSERT) && !is_full;
        cmd.del = accept && (op_t'(req.op) == OP_REMOVE) && !is_empty;
    end

    // Row of cells, each linked to both neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   occupied;
        logic   left_keep;
        value_t left_value;
        value_t right_value;

        assign occupied = (CntW'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_keep  = 1'b1;
            assign left_value = req.value;
        end
        else
        begin : g_body
            assign left_keep  = cell_keep[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = cell_value[i];
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
        end

        mpq_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .new_value   (req.value),
            .occupied    (occupied),
            .left_keep   (left_keep),
            .left_value  (left_value),
            .right_value (right_value),
            .keep        (cell_keep[i]),
            .value       (cell_value[i])
        );
    end

    // Count and response word
    always_comb
    begin
        count_next       = count_reg;
        rsp_valid_next   = rsp_valid_reg;
        status_next      = status_reg;
        removed_next     = removed_reg;
        entry_count_next = entry_count_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.del)
        begin
            count_next = count_reg - 1'b1;
        end

        if (accept)
        begin
            rsp_valid_next   = 1'b1;
            status_next      = ST_DONE;
            removed_next     = '0;
            entry_count_next = COUNT_W'(count_next);
            if (op_t'(req.op) == OP_INSERT)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
            end
            else if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                removed_next = cell_value[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        removed_reg     <= removed_next;
        entry_count_reg <= entry_count_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.entry_count   = entry_count_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(CAPACITY))
        else $error("count above capacity");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request without response");

    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_t'(req.op) == OP_REMOVE) && is_empty)
        |=> (count_reg == '0) && (status_reg == ST_EMPTY) && (removed_reg == '0))
        else $error("remove on empty changed state");

    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_t'(req.op) == OP_INSERT) && is_full)
        |=> (count_reg == $past(count_reg)) && (status_reg == ST_FULL))
        else $error("insert on full changed count");

endmodule

`default_nettype wire

[rtl/core/mpq_cell.sv]
// One cell of the sorted row: holds one value and trades it with its
// neighbors on insert and delete. Depends on mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpq_cell
    import mpq_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_cmd_t cmd,
    input  wire value_t    new_value,
    input  wire logic      occupied,     // this cell holds a live value
    input  wire logic      left_keep,    // left neighbor keeps its value
    input  wire value_t    left_value,
    input  wire value_t    right_value,
    output logic           keep,
    output value_t         value
);

    value_t value_reg;
    value_t value_next;

    // Stable order: equal values stay ahead of the new one
    assign keep  = occupied && (value_reg <= new_value);
    assign value = value_reg;

    // Next value: shift right on insert past this point, shift left on delete
    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (!keep)
            begin
                value_next = left_keep ? new_value : left_value;
            end
        end
        else if (cmd.del)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire
